FILE: hw/rtl/plob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_pkg
// shared types and constants of the price level order book
// ----------------------------------------------------------------------------
package plob_pkg;

    localparam int PRICE_W   = 32;
    localparam int DELTA_W   = 32;
    localparam int SIZE_W    = 40;
    localparam int TIME_W    = 48;
    localparam int RANK_W    = 6;
    localparam int WANT_W    = 7;
    localparam int MAX_REPORT = 64;

    localparam logic OP_UPDATE   = 1'b0;
    localparam logic OP_SNAPSHOT = 1'b1;
    localparam logic SIDE_BID    = 1'b0;
    localparam logic SIDE_ASK    = 1'b1;

    localparam logic signed [SIZE_W-1:0] SIZE_MAX = {1'b0, {(SIZE_W-1){1'b1}}};
    localparam logic signed [SIZE_W-1:0] SIZE_MIN = {1'b1, {(SIZE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_UPD_OUT,
        ST_SNAP
    } state_t;

    // command broadcast to every cell of one side
    typedef struct packed {
        logic                      apply;
        logic [PRICE_W-1:0]        price;
        logic signed [DELTA_W-1:0] delta;
        logic                      ascending;
    } cell_cmd_t;

    // what a cell hands to its neighbors
    typedef struct packed {
        logic                      valid;
        logic [PRICE_W-1:0]        price;
        logic signed [SIZE_W-1:0]  size;
        logic                      ahead;   // occupied and strictly better than the key
        logic                      hit;     // holds the key price
        logic                      remove;  // hit and sum reaches zero, or passed on from a removing cell ahead
    } cell_link_t;

    function automatic logic signed [SIZE_W-1:0] sat_add(
        input logic signed [SIZE_W-1:0]  a,
        input logic signed [DELTA_W-1:0] d
    );
        logic signed [SIZE_W:0] s;
        begin
            s = {a[SIZE_W-1], a} + {{(SIZE_W+1-DELTA_W){d[DELTA_W-1]}}, d};
            if (s > $signed({1'b0, SIZE_MAX}))
                sat_add = SIZE_MAX;
            else if (s < $signed({1'b1, SIZE_MIN}))
                sat_add = SIZE_MIN;
            else
                sat_add = s[SIZE_W-1:0];
        end
    endfunction

endpackage

FILE: hw/rtl/plob_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_cell
// one price level slot of a sorted side chain
// ----------------------------------------------------------------------------
module plob_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  plob_pkg::cell_cmd_t    cmd,
    input  plob_pkg::cell_link_t   prev_link,
    input  plob_pkg::cell_link_t   next_link,
    input  logic                   is_first,
    input  logic                   allow_insert,
    output plob_pkg::cell_link_t   link
);

    logic                                  valid_reg;
    logic                                  valid_next;
    logic [plob_pkg::PRICE_W-1:0]          price_reg;
    logic [plob_pkg::PRICE_W-1:0]          price_next;
    logic signed [plob_pkg::SIZE_W-1:0]    size_reg;
    logic signed [plob_pkg::SIZE_W-1:0]    size_next;
    logic signed [plob_pkg::SIZE_W-1:0]    sum;
    logic                                  better;
    logic                                  hit;
    logic                                  prev_ahead;
    logic                                  removed_ahead;

    assign better = cmd.ascending ? (price_reg < cmd.price) : (price_reg > cmd.price);
    assign hit    = valid_reg && (price_reg == cmd.price);
    assign sum    = plob_pkg::sat_add(size_reg, cmd.delta);

    assign link.valid  = valid_reg;
    assign link.price  = price_reg;
    assign link.size   = size_reg;
    assign link.ahead  = valid_reg && better;
    assign link.hit    = hit;
    assign link.remove = (hit && (sum == '0)) || (!is_first && prev_link.remove);

    assign prev_ahead    = is_first ? 1'b1 : prev_link.ahead;
    assign removed_ahead = !is_first && prev_link.remove;

    always_comb
    begin
        valid_next = valid_reg;
        price_next = price_reg;
        size_next  = size_reg;
        if (cmd.apply)
        begin
            if (removed_ahead || (hit && sum == '0))
            begin
                // shift up from the neighbor behind
                valid_next = next_link.valid;
                price_next = next_link.price;
                size_next  = next_link.size;
            end
            else if (hit)
            begin
                size_next = sum;
            end
            else if (allow_insert && !(valid_reg && better))
            begin
                if (prev_ahead)
                begin
                    valid_next = 1'b1;
                    price_next = cmd.price;
                    size_next  = {{(plob_pkg::SIZE_W-plob_pkg::DELTA_W){cmd.delta[plob_pkg::DELTA_W-1]}},
                                  cmd.delta};
                end
                else
                begin
                    valid_next = prev_link.valid;
                    price_next = prev_link.price;
                    size_next  = prev_link.size;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        size_reg  <= size_next;
    end

endmodule

FILE: hw/rtl/plob_side.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_side
// chain of level cells holding one side of the book, best level first
// ----------------------------------------------------------------------------
module plob_side #(
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  plob_pkg::cell_cmd_t                  cmd,
    input  logic [$clog2(plob_pkg::MAX_REPORT)-1:0] rank,
    output logic                                 any_hit,
    output logic signed [plob_pkg::SIZE_W-1:0]   hit_size,
    output logic                                 full,
    output logic                                 top_valid,
    output logic [plob_pkg::PRICE_W-1:0]         top_price,
    output logic                                 rank_valid,
    output logic [plob_pkg::PRICE_W-1:0]         rank_price,
    output logic signed [plob_pkg::SIZE_W-1:0]   rank_size
);

    localparam int RW = $clog2(plob_pkg::MAX_REPORT);

    plob_pkg::cell_link_t links [DEPTH];
    plob_pkg::cell_link_t empty_link;
    logic [DEPTH-1:0]     hits;
    logic                 allow_insert;

    assign empty_link = '0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            assign hits[g] = links[g].hit;
            plob_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .cmd          (cmd),
                .prev_link    ((g == 0) ? empty_link : links[(g == 0) ? 0 : g-1]),
                .next_link    ((g == DEPTH-1) ? empty_link : links[(g == DEPTH-1) ? g : g+1]),
                .is_first     ((g == 0) ? 1'b1 : 1'b0),
                .allow_insert (allow_insert),
                .link         (links[g])
            );
        end
    endgenerate

    assign any_hit      = |hits;
    assign full         = links[DEPTH-1].valid;
    assign allow_insert = !any_hit && !full && (cmd.delta != '0);
    assign top_valid    = links[0].valid;
    assign top_price    = links[0].price;

    // at most one cell holds the key price
    always_comb
    begin
        hit_size = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_size = hit_size | (links[i].hit ? links[i].size : '0);
        end
    end

    always_comb
    begin
        rank_valid = 1'b0;
        rank_price = '0;
        rank_size  = '0;
        for (int i = 0; i < DEPTH && i < plob_pkg::MAX_REPORT; i++)
        begin
            if (rank == RW'(i) && links[i].valid)
            begin
                rank_valid = 1'b1;
                rank_price = links[i].price;
                rank_size  = links[i].size;
            end
        end
    end

endmodule

FILE: hw/rtl/price_level_order_book.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_book
// two sorted cell chains (bids descending, asks ascending) with a report unit
// ----------------------------------------------------------------------------
// in channel: in_valid/in_ready, one item per operation (update or snapshot)
// out channel: out_valid/out_ready, results held in an output register
// cfg channel: cfg_valid/cfg_ready, writes levels_wanted, taken when idle
// an update is applied to every cell of its side in the APPLY state (compare,
// saturating add, shift), then one result shows the top of book: it is
// loaded into the output register in the UPD_OUT state that follows
// a snapshot produces levels_wanted results, clamped to 1..64, one per
// cycle while the receiver takes them, selected by rank from the cell chains
// reset empties both chains (cell valid bits), clears the held time and sets
// levels_wanted to 5; no clearing pass is needed
// a stalled receiver holds the output register; no new item is accepted
// until the last result of the current item has been taken
// ----------------------------------------------------------------------------
module price_level_order_book #(
    parameter int LEVELS_PER_SIDE = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [plob_pkg::WANT_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic                                side,
    input  logic [plob_pkg::PRICE_W-1:0]        price,
    input  logic signed [plob_pkg::DELTA_W-1:0] size_delta,
    input  logic [plob_pkg::TIME_W-1:0]         event_time,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [plob_pkg::RANK_W-1:0]         level_number,
    output logic                                bid_present,
    output logic [plob_pkg::PRICE_W-1:0]        bid_level_price,
    output logic signed [plob_pkg::SIZE_W-1:0]  bid_level_size,
    output logic                                ask_present,
    output logic [plob_pkg::PRICE_W-1:0]        ask_level_price,
    output logic signed [plob_pkg::SIZE_W-1:0]  ask_level_size,
    output logic                                book_consistent,
    output logic                                size_went_negative,
    output logic                                side_overflow,
    output logic [plob_pkg::TIME_W-1:0]         report_time,
    output logic                                last_of_run
);

    localparam int RW = plob_pkg::RANK_W;

    plob_pkg::state_t                     state_reg;
    plob_pkg::state_t                     state_next;
    logic [plob_pkg::WANT_W-1:0]          want_reg;
    logic [plob_pkg::TIME_W-1:0]          time_reg;
    logic                                 side_reg;
    logic [plob_pkg::PRICE_W-1:0]         price_reg;
    logic signed [plob_pkg::DELTA_W-1:0]  delta_reg;
    logic [RW-1:0]                        rank_reg;
    logic [RW-1:0]                        rank_next;
    logic [RW-1:0]                        last_rank;
    logic                                 neg_reg;
    logic                                 ovf_reg;

    plob_pkg::cell_cmd_t                  bid_cmd;
    plob_pkg::cell_cmd_t                  ask_cmd;
    logic                                 bid_hit, ask_hit, bid_full, ask_full;
    logic signed [plob_pkg::SIZE_W-1:0]   bid_hs, ask_hs;
    logic                                 bid_top_v, ask_top_v;
    logic [plob_pkg::PRICE_W-1:0]         bid_top_p, ask_top_p;
    logic                                 bid_rv, ask_rv;
    logic [plob_pkg::PRICE_W-1:0]         bid_rp, ask_rp;
    logic signed [plob_pkg::SIZE_W-1:0]   bid_rs, ask_rs;
    logic [RW-1:0]                        sel_rank;

    logic                                 in_fire;
    logic                                 load_out;
    logic                                 out_free;
    logic                                 apply_now;
    logic                                 hit_sel, full_sel;
    logic signed [plob_pkg::SIZE_W-1:0]   hit_size;
    logic signed [plob_pkg::SIZE_W-1:0]   hit_sum;

    assign out_free  = !out_valid || out_ready;
    assign in_ready  = (state_reg == plob_pkg::ST_IDLE) && !out_valid;
    assign cfg_ready = (state_reg == plob_pkg::ST_IDLE) && !out_valid;
    assign in_fire   = in_valid && in_ready;
    assign apply_now = (state_reg == plob_pkg::ST_APPLY);

    assign bid_cmd.apply     = apply_now && (side_reg == plob_pkg::SIDE_BID);
    assign bid_cmd.price     = price_reg;
    assign bid_cmd.delta     = delta_reg;
    assign bid_cmd.ascending = 1'b0;
    assign ask_cmd.apply     = apply_now && (side_reg == plob_pkg::SIDE_ASK);
    assign ask_cmd.price     = price_reg;
    assign ask_cmd.delta     = delta_reg;
    assign ask_cmd.ascending = 1'b1;

    assign sel_rank = (state_reg == plob_pkg::ST_SNAP) ? rank_reg : '0;

    plob_side #(.DEPTH(LEVELS_PER_SIDE)) u_bids (
        .clk (clk), .rst_n (rst_n), .cmd (bid_cmd), .rank (sel_rank),
        .any_hit (bid_hit), .hit_size (bid_hs), .full (bid_full),
        .top_valid (bid_top_v), .top_price (bid_top_p),
        .rank_valid (bid_rv), .rank_price (bid_rp), .rank_size (bid_rs)
    );

    plob_side #(.DEPTH(LEVELS_PER_SIDE)) u_asks (
        .clk (clk), .rst_n (rst_n), .cmd (ask_cmd), .rank (sel_rank),
        .any_hit (ask_hit), .hit_size (ask_hs), .full (ask_full),
        .top_valid (ask_top_v), .top_price (ask_top_p),
        .rank_valid (ask_rv), .rank_price (ask_rp), .rank_size (ask_rs)
    );

    assign hit_size = (side_reg == plob_pkg::SIDE_ASK) ? ask_hs : bid_hs;
    assign hit_sel  = (side_reg == plob_pkg::SIDE_ASK) ? ask_hit : bid_hit;
    assign full_sel = (side_reg == plob_pkg::SIDE_ASK) ? ask_full : bid_full;
    assign hit_sum  = plob_pkg::sat_add(hit_size, delta_reg);

    always_comb
    begin
        if (want_reg == '0)
            last_rank = '0;
        else if (want_reg > plob_pkg::WANT_W'(plob_pkg::MAX_REPORT))
            last_rank = '1;
        else
            last_rank = RW'(want_reg - 1'b1);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plob_pkg::ST_IDLE:
            begin
                if (in_fire)
                    state_next = (operation == plob_pkg::OP_SNAPSHOT) ?
                                 plob_pkg::ST_SNAP : plob_pkg::ST_APPLY;
            end
            plob_pkg::ST_APPLY:   state_next = plob_pkg::ST_UPD_OUT;
            plob_pkg::ST_UPD_OUT: state_next = plob_pkg::ST_IDLE;
            plob_pkg::ST_SNAP:
            begin
                if (out_free && rank_reg == last_rank)
                    state_next = plob_pkg::ST_IDLE;
            end
            default: state_next = plob_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        load_out  = 1'b0;
        rank_next = rank_reg;
        case (state_reg)
            plob_pkg::ST_IDLE:    rank_next = '0;
            plob_pkg::ST_APPLY:   load_out = 1'b0;
            plob_pkg::ST_UPD_OUT: load_out = 1'b1;
            plob_pkg::ST_SNAP:
            begin
                load_out = out_free;
                if (out_free)
                    rank_next = rank_reg + 1'b1;
            end
            default: load_out = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plob_pkg::ST_IDLE;
            want_reg  <= plob_pkg::WANT_W'(5);
            time_reg  <= '0;
            rank_reg  <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rank_reg  <= rank_next;
            if (cfg_valid && cfg_ready)
                want_reg <= cfg_data;
            if (in_fire && operation == plob_pkg::OP_UPDATE)
                time_reg <= event_time;
            if (load_out)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            side_reg  <= side;
            price_reg <= price;
            delta_reg <= size_delta;
        end
        if (apply_now)
        begin
            neg_reg <= hit_sel ? (hit_sum != '0 && hit_sum[plob_pkg::SIZE_W-1])
                               : (!full_sel && delta_reg[plob_pkg::DELTA_W-1]);
            ovf_reg <= !hit_sel && full_sel && (delta_reg != '0);
        end
        if (load_out)
        begin
            level_number       <= sel_rank;
            bid_present        <= bid_rv;
            bid_level_price    <= bid_rv ? bid_rp : '0;
            bid_level_size     <= bid_rv ? bid_rs : '0;
            ask_present        <= ask_rv;
            ask_level_price    <= ask_rv ? ask_rp : '0;
            ask_level_size     <= ask_rv ? ask_rs : '0;
            book_consistent    <= !bid_top_v || !ask_top_v || (bid_top_p <= ask_top_p);
            size_went_negative <= (state_reg == plob_pkg::ST_UPD_OUT) ? neg_reg : 1'b0;
            side_overflow      <= (state_reg == plob_pkg::ST_UPD_OUT) ? ovf_reg : 1'b0;
            report_time        <= time_reg;
            last_of_run        <= (state_reg == plob_pkg::ST_UPD_OUT) ||
                                  (rank_reg == last_rank);
        end
    end

endmodule

FILE: hw/rtl/plob_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_checker
// port level checks of the price level order book
// ----------------------------------------------------------------------------
module plob_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] level_number,
    input logic       last_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level_number))
        else $error("result dropped while stalled");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("item accepted while a result is pending");

    a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run ##1 out_valid |->
        level_number == $past(level_number) + 6'd1)
        else $error("snapshot rank skipped");

    a_first_rank: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result before work");

endmodule

bind price_level_order_book plob_checker u_plob_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .level_number (level_number),
    .last_of_run  (last_of_run)
);

FILE: tb/price_level_order_book_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_book_checker
// watches the item, result and register channels of the order book, keeps a
// behavioral copy of both level tables and compares every result in order
// ----------------------------------------------------------------------------
module price_level_order_book_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [plob_pkg::WANT_W-1:0]         cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                operation,
    input  logic                                side,
    input  logic [plob_pkg::PRICE_W-1:0]        price,
    input  logic signed [plob_pkg::DELTA_W-1:0] size_delta,
    input  logic [plob_pkg::TIME_W-1:0]         event_time,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [plob_pkg::RANK_W-1:0]         level_number,
    input  logic                                bid_present,
    input  logic [plob_pkg::PRICE_W-1:0]        bid_level_price,
    input  logic signed [plob_pkg::SIZE_W-1:0]  bid_level_size,
    input  logic                                ask_present,
    input  logic [plob_pkg::PRICE_W-1:0]        ask_level_price,
    input  logic signed [plob_pkg::SIZE_W-1:0]  ask_level_size,
    input  logic                                book_consistent,
    input  logic                                size_went_negative,
    input  logic                                side_overflow,
    input  logic [plob_pkg::TIME_W-1:0]         report_time,
    input  logic                                last_of_run,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  results_seen,
    output int                                  flag_neg_seen,
    output int                                  flag_ovf_seen
);

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [plob_pkg::RANK_W-1:0]        rank;
        logic                               bp;
        logic [plob_pkg::PRICE_W-1:0]       bpr;
        logic signed [plob_pkg::SIZE_W-1:0] bsz;
        logic                               ap;
        logic [plob_pkg::PRICE_W-1:0]       apr;
        logic signed [plob_pkg::SIZE_W-1:0] asz;
        logic                               cons;
        logic                               neg;
        logic                               ovf;
        logic [plob_pkg::TIME_W-1:0]        tm;
        logic                               last;
    } book_row_t;

    logic [plob_pkg::PRICE_W-1:0]       bid_px [DEPTH];
    logic signed [plob_pkg::SIZE_W-1:0] bid_qty [DEPTH];
    logic [plob_pkg::PRICE_W-1:0]       ask_px [DEPTH];
    logic signed [plob_pkg::SIZE_W-1:0] ask_qty [DEPTH];
    int                                 n_bid, n_ask;
    logic [plob_pkg::TIME_W-1:0]        book_time;
    logic [plob_pkg::WANT_W-1:0]        depth_wanted;
    book_row_t                          expected_rows[$];

    function automatic book_row_t make_row(int r, logic ng, logic ov, logic lst);
        book_row_t row;
        row = '0;
        row.rank = r[plob_pkg::RANK_W-1:0];
        if (r < n_bid) begin row.bp = 1; row.bpr = bid_px[r]; row.bsz = bid_qty[r]; end
        if (r < n_ask) begin row.ap = 1; row.apr = ask_px[r]; row.asz = ask_qty[r]; end
        row.cons = (n_bid == 0 || n_ask == 0) || (bid_px[0] <= ask_px[0]);
        row.neg = ng;
        row.ovf = ov;
        row.tm = book_time;
        row.last = lst;
        return row;
    endfunction

    task automatic apply_delta(input logic sd, input logic [plob_pkg::PRICE_W-1:0] p,
                               input logic signed [plob_pkg::DELTA_W-1:0] d,
                               output logic ng, output logic ov);
        logic [plob_pkg::PRICE_W-1:0]       px [DEPTH];
        logic signed [plob_pkg::SIZE_W-1:0] qty [DEPTH];
        int n, pos;
        logic signed [plob_pkg::SIZE_W+1:0] s;
        ng = 0; ov = 0;
        if (sd == plob_pkg::SIDE_ASK) begin px = ask_px; qty = ask_qty; n = n_ask; end
        else begin px = bid_px; qty = bid_qty; n = n_bid; end
        pos = 0;
        while (pos < n && px[pos] != p &&
               !(sd == plob_pkg::SIDE_ASK ? px[pos] > p : px[pos] < p)) pos++;
        if (pos < n && px[pos] == p) begin
            s = qty[pos] + d;
            if (s > plob_pkg::SIZE_MAX) s = plob_pkg::SIZE_MAX;
            if (s < plob_pkg::SIZE_MIN) s = plob_pkg::SIZE_MIN;
            if (s == 0) begin
                for (int i = pos; i < n - 1; i++) begin
                    px[i] = px[i+1]; qty[i] = qty[i+1];
                end
                n--;
            end else begin
                qty[pos] = s[plob_pkg::SIZE_W-1:0];
                ng = s < 0;
            end
        end else if (d != 0) begin
            if (n >= DEPTH) ov = 1;
            else begin
                for (int i = n; i > pos; i--) begin
                    px[i] = px[i-1]; qty[i] = qty[i-1];
                end
                px[pos] = p; qty[pos] = d; n++;
                ng = d < 0;
            end
        end
        if (sd == plob_pkg::SIDE_ASK) begin ask_px = px; ask_qty = qty; n_ask = n; end
        else begin bid_px = px; bid_qty = qty; n_bid = n; end
    endtask

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0; results_seen = 0; flag_neg_seen = 0; flag_ovf_seen = 0;
        n_bid = 0; n_ask = 0; book_time = '0; depth_wanted = 5;
    end

    assign pending = expected_rows.size();

    always @(posedge clk) begin
        book_row_t w;
        logic ng, ov;
        int cnt;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_rows.size() == 0) begin
                    $error("result with nothing expected");
                    fail_count++;
                end else begin
                    w = expected_rows.pop_front();
                    compare_field("level_number", w.rank, level_number);
                    compare_field("bid_present", w.bp, bid_present);
                    compare_field("bid_level_price", w.bpr, bid_level_price);
                    compare_field("bid_level_size", w.bsz, bid_level_size);
                    compare_field("ask_present", w.ap, ask_present);
                    compare_field("ask_level_price", w.apr, ask_level_price);
                    compare_field("ask_level_size", w.asz, ask_level_size);
                    compare_field("book_consistent", w.cons, book_consistent);
                    compare_field("size_went_negative", w.neg, size_went_negative);
                    compare_field("side_overflow", w.ovf, side_overflow);
                    compare_field("report_time", w.tm, report_time);
                    compare_field("last_of_run", w.last, last_of_run);
                end
            end
            if (cfg_valid && cfg_ready) depth_wanted = cfg_data;
            if (in_valid && in_ready) begin
                if (operation == plob_pkg::OP_UPDATE) begin
                    apply_delta(side, price, size_delta, ng, ov);
                    book_time = event_time;
                    flag_neg_seen += ng;
                    flag_ovf_seen += ov;
                    expected_rows.push_back(make_row(0, ng, ov, 1'b1));
                end else begin
                    cnt = depth_wanted == 0 ? 1 : (depth_wanted > plob_pkg::MAX_REPORT ?
                          plob_pkg::MAX_REPORT : depth_wanted);
                    for (int k = 0; k < cnt; k++)
                        expected_rows.push_back(make_row(k, 1'b0, 1'b0, k == cnt - 1));
                end
            end
        end
    end

endmodule

FILE: tb/price_level_order_book_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_book_test
// drives updates, snapshots and depth settings into the order book with random
// gaps and receiver stalls; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module price_level_order_book_test;

    logic                                clk, rst_n;
    logic                                cfg_valid, cfg_ready;
    logic [plob_pkg::WANT_W-1:0]         cfg_data;
    logic                                in_valid, in_ready;
    logic                                operation, side;
    logic [plob_pkg::PRICE_W-1:0]        price;
    logic signed [plob_pkg::DELTA_W-1:0] size_delta;
    logic [plob_pkg::TIME_W-1:0]         event_time;
    logic                                out_valid, out_ready;
    logic [plob_pkg::RANK_W-1:0]         level_number;
    logic                                bid_present, ask_present;
    logic [plob_pkg::PRICE_W-1:0]        bid_level_price, ask_level_price;
    logic signed [plob_pkg::SIZE_W-1:0]  bid_level_size, ask_level_size;
    logic                                book_consistent, size_went_negative, side_overflow;
    logic [plob_pkg::TIME_W-1:0]         report_time;
    logic                                last_of_run;
    int                                  fail_count, pending, results_seen;
    int                                  flag_neg_seen, flag_ovf_seen;
    int                                  items_sent;
    logic                                calm;
    logic [plob_pkg::PRICE_W-1:0]        base_px;

    price_level_order_book DUT (.*);
    price_level_order_book_checker chk (.*);

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // receiver stalls, none while calm
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 21);

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_item(logic op, logic sd, logic [plob_pkg::PRICE_W-1:0] p,
                             logic signed [plob_pkg::DELTA_W-1:0] d,
                             logic [plob_pkg::TIME_W-1:0] t);
        while (!calm && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1; operation <= op; side <= sd;
        price <= p; size_delta <= d; event_time <= t;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_depth(logic [plob_pkg::WANT_W-1:0] v);
        drain();
        cfg_valid <= 1'b1; cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [plob_pkg::TIME_W-1:0] rand_time();
        return plob_pkg::TIME_W'({$urandom(), $urandom()});
    endfunction

    initial
    begin
        logic [plob_pkg::PRICE_W-1:0] p;
        logic signed [plob_pkg::DELTA_W-1:0] d;
        int r;
        rst_n = 1'b0; cfg_valid = 1'b0; cfg_data = '0; in_valid = 1'b0;
        operation = plob_pkg::OP_UPDATE; side = plob_pkg::SIDE_BID; price = '0;
        size_delta = '0; event_time = '0; out_ready = 1'b0; calm = 1'b0; items_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_item(plob_pkg::OP_SNAPSHOT, plob_pkg::SIDE_BID, '0, '0, '0);
        send_item(plob_pkg::OP_UPDATE, plob_pkg::SIDE_BID, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, '1);
        send_item(plob_pkg::OP_UPDATE, plob_pkg::SIDE_ASK, 32'h0, 32'sh8000_0000, 48'h1);
        send_item(plob_pkg::OP_UPDATE, plob_pkg::SIDE_ASK, 32'h10, 32'sd0, 48'h2);
        send_item(plob_pkg::OP_UPDATE, plob_pkg::SIDE_BID, 32'h100, -32'sd5, 48'h3);
        send_item(plob_pkg::OP_UPDATE, plob_pkg::SIDE_BID, 32'h100, 32'sd5, 48'h4);
        send_item(plob_pkg::OP_UPDATE, plob_pkg::SIDE_ASK, 32'h0, 32'sh7FFF_FFFF, 48'h5);
        send_item(plob_pkg::OP_UPDATE, plob_pkg::SIDE_ASK, 32'h0, -32'sh7FFF_FFFF, 48'h6);
        // enough maximum deltas to clamp the level at the top of its range
        for (int i = 0; i < 258; i++)
            send_item(plob_pkg::OP_UPDATE, plob_pkg::SIDE_BID, 32'h5000, 32'sh7FFF_FFFF,
                      rand_time());
        send_item(plob_pkg::OP_UPDATE, plob_pkg::SIDE_BID, 32'h5000, 32'sh8000_0000, 48'h7);
        send_item(plob_pkg::OP_SNAPSHOT, plob_pkg::SIDE_ASK, '0, '0, '0);
        write_depth(7'd0);
        send_item(plob_pkg::OP_SNAPSHOT, plob_pkg::SIDE_BID, '0, '0, '0);
        write_depth(7'd127);
        send_item(plob_pkg::OP_SNAPSHOT, plob_pkg::SIDE_BID, '0, '0, '0);

        // fill the ask side past capacity around the random price cluster
        write_depth(7'd64);
        base_px = $urandom();
        for (int i = 0; i < 66; i++)
            send_item(plob_pkg::OP_UPDATE, plob_pkg::SIDE_ASK,
                      base_px + plob_pkg::PRICE_W'(i), $urandom_range(1, 900), rand_time());
        send_item(plob_pkg::OP_SNAPSHOT, plob_pkg::SIDE_BID, '0, '0, '0);

        // random part, clustered prices so levels hit and cancel
        write_depth(7'd3);
        for (int i = 0; i < 44; i++)
        begin
            if (i == 10) write_depth(plob_pkg::WANT_W'($urandom_range(1, 12)));
            if (i == 30) drain();
            if (i == 34) write_depth(7'd64);
            if (i == 38) write_depth(7'd4);
            calm <= (i >= 12 && i < 30);
            r = $urandom_range(99);
            p = base_px + $urandom_range(0, 40);
            if (r < 5) p = $urandom();
            d = $signed($urandom_range(0, 2000)) - 1000;
            if (r >= 90) d = $urandom();
            if (r < 2) d = 0;
            if (r >= 5 && r < 13)
                send_item(plob_pkg::OP_SNAPSHOT, 1'($urandom_range(1)), $urandom(), $urandom(),
                          rand_time());
            else
                send_item(plob_pkg::OP_UPDATE, 1'($urandom_range(1)), p, d, rand_time());
        end
        calm <= 1'b0;
        drain();

        $display("sent %0d items, %0d results, %0d negative-size and %0d overflow flags",
                 items_sent, results_seen, flag_neg_seen, flag_ovf_seen);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/plob_pkg.sv
hw/rtl/plob_cell.sv
hw/rtl/plob_side.sv
hw/rtl/price_level_order_book.sv
hw/rtl/plob_checker.sv
tb/price_level_order_book_checker.sv
tb/price_level_order_book_test.sv
